[rtl/core/wma_pkg.sv]
// Shared constants and types of the weighted moving average unit.
package wma_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH  = 2'd3;

    // Register field widths
    localparam int WLEN_W     = 5;
    localparam int LANE_W     = 8;
    localparam int NUM_LANES  = 16;
    localparam int WEIGHTS_W  = NUM_LANES * LANE_W;

    // Reset values
    localparam logic [WLEN_W-1:0]     WINDOW_LEN_RST = 5'd4;
    localparam logic [CFG_DATA_W-1:0] WEIGHTS_RST    = 64'h0101_0101_0101_0101;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Mode settings seen by the front end
    typedef struct packed {
        logic [WLEN_W-1:0] window_len;
        logic              weighted_mode;
    } wma_mode_t;

endpackage

[rtl/core/wma_front.sv]
// Front end: accepts samples, clamps the window length and tags the mode.
module wma_front #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_W       = 5,
    parameter int ITEM_W      = 22
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wma_pkg::wma_mode_t     mode,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [ITEM_W-1:0]      push_data
);
    import wma_pkg::*;

    localparam int CW = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

    logic              item_valid_reg, item_valid_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic [CW-1:0]     len_ext;
    logic [LEN_W-1:0]  len_clamped;
    logic              accept;

    assign s_ready    = !item_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = item_valid_reg;
    assign push_data  = item_reg;

    // Clamp the window length into 1..WINDOW_MAX
    always_comb begin
        len_ext = CW'(mode.window_len);
        if (len_ext == '0) begin
            len_clamped = LEN_W'(1);
        end else if (len_ext > CW'(WINDOW_MAX)) begin
            len_clamped = LEN_W'(WINDOW_MAX);
        end else begin
            len_clamped = LEN_W'(len_ext);
        end
    end

    always_comb begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (accept) begin
            item_valid_next = 1'b1;
            item_next       = {s_sample, mode.weighted_mode, len_clamped};
        end else if (push_ready) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

[rtl/core/wma_fifo.sv]
// Short queue between the front end and the back end.
module wma_fifo #(
    parameter int DATA_W = 22
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import wma_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/wma_div.sv]
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module wma_div #(
    parameter int ACC_W = 29,
    parameter int WS_W  = 12,
    parameter int Q_W   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [WS_W-1:0]         divisor,
    output logic                    done,
    output logic signed [Q_W-1:0]   quotient
);
    localparam int DS_W  = WS_W + Q_W;
    localparam int CMPW  = (ACC_W > DS_W) ? ACC_W : DS_W;
    localparam int STP_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [DS_W-1:0]  dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             neg_reg, neg_next;
    logic [STP_W-1:0] step_reg, step_next;
    logic             ge;

    assign ge       = CMPW'(rem_reg) >= CMPW'(dsh_reg);
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-q_reg) : $signed(q_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        if (start) begin
            // Work on magnitudes, fix the sign at the end
            busy_next = 1'b1;
            neg_next  = dividend[ACC_W-1];
            rem_next  = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            dsh_next  = DS_W'(divisor) << (Q_W - 1);
            q_next    = '0;
            step_next = STP_W'(Q_W);
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - ACC_W'(dsh_reg);
            end
            q_next    = {q_reg[Q_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STP_W'(1);
            if (step_reg == STP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

endmodule

[rtl/core/wma_back.sv]
// Back end: sample history memory, serial multiply-accumulate, divide, result register.
module wma_back #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 8,
    parameter int LEN_W       = 5,
    parameter int ITEM_W      = 22
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wma_pkg::WEIGHTS_W-1:0] weights,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [ITEM_W-1:0]             pop_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    output logic                          m_weight_sum_zero
);
    import wma_pkg::*;

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CL    = $clog2(WINDOW_MAX);
    localparam int WE    = (WEIGHT_BITS < LANE_W) ? WEIGHT_BITS : LANE_W;
    localparam int PRW   = SAMPLE_BITS + WE + 1;
    localparam int ACC_W = SAMPLE_BITS + WE + CL + 1;
    localparam int WS_W  = WE + CL;
    localparam int IXW   = (LEN_W > 5) ? LEN_W : 5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                    state_reg, state_next;

    // History memory, newest sample written at wr_ptr
    logic [SAMPLE_BITS-1:0]        mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         vld_reg, vld_next;
    logic [AW-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]              cnt_reg, cnt_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic                          mode_reg, mode_next;

    // Pipeline: read, multiply, accumulate
    logic                          b_valid_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_vld_reg;
    logic [WE-1:0]                 w_b_reg;
    logic                          c_valid_reg;
    logic signed [PRW-1:0]         prod_reg;
    logic [WE-1:0]                 w_c_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [WS_W-1:0]               wsum_reg, wsum_next;

    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic                          zf_reg, zf_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_average_reg;
    logic                          m_zero_reg;

    logic                          pop;
    logic                          issue;
    logic                          load_out;
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_q;
    logic [SAMPLE_BITS-1:0]        in_sample;
    logic [LANE_W-1:0]             lane_arr [NUM_LANES];
    logic [LEN_W-1:0]              widx;
    logic [IXW-1:0]                widx_ext;
    logic [WE-1:0]                 w_sel;
    logic signed [SAMPLE_BITS-1:0] s_eff;
    logic signed [WE:0]            w_sig;

    assign in_sample = pop_data[ITEM_W-1 -: SAMPLE_BITS];
    assign pop_ready = (state_reg == ST_IDLE);
    assign pop       = pop_valid && pop_ready;
    assign issue     = (state_reg == ST_MAC);
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign m_valid           = m_valid_reg;
    assign m_average         = m_average_reg;
    assign m_weight_sum_zero = m_zero_reg;

    // Entry weight: 1 in plain mode, else lane (len-1-cnt), zero past the lane table
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_arr[i] = weights[i*LANE_W +: LANE_W];
        end
        widx     = len_reg - LEN_W'(1) - cnt_reg;
        widx_ext = IXW'(widx);
        if (!mode_reg) begin
            w_sel = WE'(1);
        end else if (widx_ext < IXW'(NUM_LANES)) begin
            w_sel = lane_arr[widx_ext[3:0]][WE-1:0];
        end else begin
            w_sel = '0;
        end
    end

    assign s_eff = rd_vld_reg ? rd_data_reg : '0;
    assign w_sig = $signed({1'b0, w_b_reg});

    always_comb begin
        state_next   = state_reg;
        vld_next     = vld_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        wsum_next    = wsum_reg;
        res_next     = res_reg;
        zf_next      = zf_reg;
        div_start    = 1'b0;
        m_valid_next = m_valid_reg;

        if (c_valid_reg) begin
            acc_next  = acc_reg + ACC_W'(prod_reg);
            wsum_next = wsum_reg + WS_W'(w_c_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    vld_next[wr_ptr_reg] = 1'b1;
                    rd_addr_next = wr_ptr_reg;
                    wr_ptr_next  = (wr_ptr_reg == AW'(WINDOW_MAX-1)) ? '0
                                                                      : wr_ptr_reg + AW'(1);
                    cnt_next     = '0;
                    len_next     = pop_data[LEN_W-1:0];
                    mode_next    = pop_data[LEN_W];
                    acc_next     = '0;
                    wsum_next    = '0;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC: begin
                // Walk from newest to older entries
                rd_addr_next = (rd_addr_reg == '0) ? AW'(WINDOW_MAX-1)
                                                   : rd_addr_reg - AW'(1);
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == len_reg - LEN_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!b_valid_reg && !c_valid_reg) begin
                    if (wsum_reg == '0) begin
                        res_next   = '0;
                        zf_next    = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = div_q;
                    zf_next    = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            wr_ptr_reg  <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            wr_ptr_reg  <= wr_ptr_next;
            b_valid_reg <= issue;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            mem[wr_ptr_reg] <= in_sample;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        cnt_reg     <= cnt_next;
        len_reg     <= len_next;
        mode_reg    <= mode_next;
        rd_vld_reg  <= vld_reg[rd_addr_reg];
        w_b_reg     <= w_sel;
        prod_reg    <= PRW'(s_eff) * PRW'(w_sig);
        w_c_reg     <= w_b_reg;
        acc_reg     <= acc_next;
        wsum_reg    <= wsum_next;
        res_reg     <= res_next;
        zf_reg      <= zf_next;
        if (load_out) begin
            m_average_reg <= res_reg;
            m_zero_reg    <= zf_reg;
        end
    end

    wma_div #(
        .ACC_W (ACC_W),
        .WS_W  (WS_W),
        .Q_W   (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (wsum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

[rtl/core/weighted_moving_average_unit.sv]
// Top level of the weighted moving average unit: configuration registers and datapath.
//
// Usage:
//   Input channel s_valid/s_ready/s_sample carries one signed sample per request.
//   Each request shifts its sample into the history and yields exactly one result
//   on m_valid/m_ready (m_average, m_weight_sum_zero), in order.
//   Plain mode returns the sum of the newest window_len samples divided by
//   window_len; weighted mode multiplies by per-position weights (lane 0 on
//   the oldest sample) and divides by the weight sum. Quotients truncate
//   toward zero. A zero weight sum gives average 0 with m_weight_sum_zero set.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata; the user must write it only
//   while idle, which the block itself does not enforce. The back end sets the
//   pace and takes a new sample only after the last result has entered the
//   result register: one multiply-accumulate per history entry read from the
//   sample memory, then one quotient bit per cycle in the serial divider.
//   From accept, a sample passes the front-end register and the queue first.
//   The front end and a two-entry queue keep taking samples while the back
//   end works or while a finished result waits for m_ready, until they fill;
//   a stalled receiver holds the result register, then the back end, then s_ready.
//   Reset: history reads as zero, window_len 4, plain mode, all weights 1.
module weighted_moving_average_unit #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [wma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample,
    // Result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_average,
    output logic                             m_weight_sum_zero
);
    import wma_pkg::*;

    // Clamped window length fits 0..WINDOW_MAX
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    // Queue item: sample, mode bit, clamped length
    localparam int ITEM_W = SAMPLE_BITS + 1 + LEN_W;

    logic [WLEN_W-1:0]     window_len_reg, window_len_next;
    logic                  weighted_mode_reg, weighted_mode_next;
    logic [CFG_DATA_W-1:0] weights_low_reg, weights_low_next;
    logic [CFG_DATA_W-1:0] weights_high_reg, weights_high_next;

    wma_mode_t             mode;
    logic [WEIGHTS_W-1:0]  weights;

    logic                  push_valid, push_ready;
    logic [ITEM_W-1:0]     push_data;
    logic                  pop_valid, pop_ready;
    logic [ITEM_W-1:0]     pop_data;

    // Register writes; indexes outside the list fall through untouched
    always_comb begin
        window_len_next    = window_len_reg;
        weighted_mode_next = weighted_mode_reg;
        weights_low_next   = weights_low_reg;
        weights_high_next  = weights_high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_LEN:    window_len_next    = cfg_wdata[WLEN_W-1:0];
                REG_WEIGHTED_MODE: weighted_mode_next = cfg_wdata[0];
                REG_WEIGHTS_LOW:   weights_low_next   = cfg_wdata;
                REG_WEIGHTS_HIGH:  weights_high_next  = cfg_wdata;
                default: begin
                    window_len_next = window_len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg    <= WINDOW_LEN_RST;
            weighted_mode_reg <= 1'b0;
            weights_low_reg   <= WEIGHTS_RST;
            weights_high_reg  <= WEIGHTS_RST;
        end else begin
            window_len_reg    <= window_len_next;
            weighted_mode_reg <= weighted_mode_next;
            weights_low_reg   <= weights_low_next;
            weights_high_reg  <= weights_high_next;
        end
    end

    assign mode.window_len    = window_len_reg;
    assign mode.weighted_mode = weighted_mode_reg;
    // Lane 0 (oldest position) sits in the low byte
    assign weights = {weights_high_reg, weights_low_reg};

    // Front end: take the request, clamp length, tag mode
    wma_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_W       (LEN_W),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the front end from the long back-end computation
    wma_fifo #(
        .DATA_W (ITEM_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: history, accumulate, divide, hold the result for the receiver
    wma_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .LEN_W       (LEN_W),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .weights           (weights),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_data          (pop_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_average         (m_average),
        .m_weight_sum_zero (m_weight_sum_zero)
    );

endmodule
